// File: rtl/cdn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdn_pkg
// Shared types, constants and calendar helpers for the date normalizer.
// ----------------------------------------------------------------------------
package cdn_pkg;

  localparam int DEF_DAY_BITS  = 16;
  localparam int DEF_YEAR_BITS = 16;
  localparam int MONTH_BITS    = 9;
  localparam int YEAR_GUARD    = 24;
  localparam int CYCLE_DAYS    = 146097;
  localparam int CYCLE_YEARS   = 400;
  localparam int MONTHS        = 12;

  localparam logic [3:0] JANUARY  = 4'd0;
  localparam logic [3:0] FEBRUARY = 4'd1;
  localparam logic [3:0] DECEMBER = 4'd11;
  localparam logic [8:0] YMOD_MAX = 9'd399;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic mod_fix;
    logic fold;
    logic cyc;
    logic back;
    logic fwd;
    logic store;
  } cdn_cmd_t;

  typedef struct packed {
    logic mon_out;
    logic day_far;
    logic day_neg;
    logic day_ge_len;
    logic out_busy;
  } cdn_sts_t;

  function automatic logic is_leap(input logic [8:0] ymod);
    is_leap = (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
              && (ymod != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    case (mon)
      FEBRUARY:                month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: month_len = 5'd30;
      default:                 month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [8:0] ymod_inc(input logic [8:0] ymod);
    ymod_inc = (ymod == YMOD_MAX) ? 9'd0 : ymod + 9'd1;
  endfunction

  function automatic logic [8:0] ymod_dec(input logic [8:0] ymod);
    ymod_dec = (ymod == 9'd0) ? YMOD_MAX : ymod - 9'd1;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cdn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdn_ctrl
// Sequencer: year residue, month fold, 400-year moves, month stepping.
// ----------------------------------------------------------------------------
module cdn_ctrl
  import cdn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_ready,
  input  wire cdn_sts_t sts,
  output cdn_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_CYC  = 3'd4;
  localparam logic [2:0] S_BACK = 3'd5;
  localparam logic [2:0] S_FWD  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        state_next   = S_FIX;
      end
      S_FIX: begin
        cmd.mod_fix = 1'b1;
        state_next  = S_FOLD;
      end
      S_FOLD: begin
        if (sts.mon_out) cmd.fold = 1'b1;
        else state_next = S_CYC;
      end
      S_CYC: begin
        if (sts.day_far) cmd.cyc = 1'b1;
        else state_next = S_BACK;
      end
      S_BACK: begin
        if (sts.day_neg) cmd.back = 1'b1;
        else state_next = S_FWD;
      end
      S_FWD: begin
        if (sts.day_ge_len) cmd.fwd = 1'b1;
        else state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy || out_ready) begin
          cmd.store  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/cdn_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdn_dp
// Datapath: day, month, wide year, year residue mod 400, output register.
// ----------------------------------------------------------------------------
module cdn_dp
  import cdn_pkg::*;
#(
  parameter int DAY_BITS  = DEF_DAY_BITS,
  parameter int YEAR_BITS = DEF_YEAR_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cdn_cmd_t                    cmd,
  output cdn_sts_t                         sts,
  input  wire logic signed [DAY_BITS-1:0]  day_offset,
  input  wire logic signed [MONTH_BITS-1:0] month_offset,
  input  wire logic signed [YEAR_BITS-1:0] year_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [4:0]                       day_out,
  output logic [3:0]                       month_out,
  output logic [YEAR_BITS-1:0]             year_out,
  output logic                             year_overflow
);

  localparam int DW = (DAY_BITS > 18) ? DAY_BITS + 1 : 20;
  localparam int YW = YEAR_BITS + YEAR_GUARD;
  localparam int QW = YEAR_BITS - 4;
  localparam int PW = QW + 33;
  localparam int XW = YEAR_BITS + 1;
  localparam logic signed [DW-1:0] CYC_D = DW'(CYCLE_DAYS);
  localparam logic signed [YW-1:0] CYC_Y = YW'(CYCLE_YEARS);
  localparam logic signed [YW-1:0] ONE_Y = YW'(1);
  localparam logic signed [MONTH_BITS-1:0] M12 = MONTH_BITS'(MONTHS);
  // ceil(2^33 / 25), exact quotient for dividends below 2^30
  localparam logic [PW-1:0] RCP25 = PW'(343597384);
  localparam logic [XW-1:0] D25   = XW'(25);

  logic signed [DW-1:0]         day;
  logic signed [MONTH_BITS-1:0] mon;
  logic signed [YW-1:0]         year;
  logic [8:0]                   ymod;
  logic [YEAR_BITS-1:0]         mag;
  logic                         yneg;
  logic [QW-1:0]                quo;

  logic [QW-1:0] mag_hi;
  logic [PW-1:0] prod;
  logic [XW-1:0] rem25;
  logic [8:0]    res;
  logic [3:0]  mon_lo;
  logic [3:0]  prev_mon;
  logic        wrap_back;
  logic [4:0]  len_back;
  logic [4:0]  len_cur;
  logic        mon_neg;
  logic        mon_big;
  logic        day_big;
  logic [YW-YEAR_BITS:0] year_hi;

  // |year| mod 400 = 16 * ((|year| >> 4) mod 25) + (|year| & 15)
  assign mag_hi    = mag[YEAR_BITS-1:4];
  assign prod      = PW'(mag_hi) * RCP25;
  assign rem25     = XW'(mag_hi) - XW'(quo) * D25;
  assign res       = {rem25[4:0], mag[3:0]};
  assign mon_lo    = mon[3:0];
  assign wrap_back = (mon_lo == JANUARY);
  assign prev_mon  = wrap_back ? DECEMBER : mon_lo - 4'd1;
  assign len_back  = month_len(prev_mon, is_leap(wrap_back ? ymod_dec(ymod) : ymod));
  assign len_cur   = month_len(mon_lo, is_leap(ymod));
  assign mon_neg   = mon[MONTH_BITS-1];
  assign mon_big   = !mon_neg && (mon >= M12);
  assign day_big   = (day >= CYC_D);
  assign year_hi   = year[YW-1:YEAR_BITS-1];

  always_comb begin
    sts            = '0;
    sts.mon_out    = mon_neg || mon_big;
    sts.day_far    = day_big || (day <= -CYC_D);
    sts.day_neg    = day[DW-1];
    sts.day_ge_len = (day >= $signed({{(DW-5){1'b0}}, len_cur}));
    sts.out_busy   = out_valid;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day  <= DW'(day_offset);
      mon  <= month_offset;
      year <= YW'(year_in);
      yneg <= year_in[YEAR_BITS-1];
      mag  <= year_in[YEAR_BITS-1] ? YEAR_BITS'(-year_in) : year_in;
      ymod <= 9'd0;
    end
    if (cmd.mod_step) begin
      quo <= prod[PW-1:33];
    end
    if (cmd.mod_fix) begin
      ymod <= (yneg && (res != 9'd0)) ? 9'd400 - res : res;
    end
    if (cmd.fold) begin
      if (mon_neg) begin
        mon  <= mon + M12;
        year <= year - ONE_Y;
        ymod <= ymod_dec(ymod);
      end else begin
        mon  <= mon - M12;
        year <= year + ONE_Y;
        ymod <= ymod_inc(ymod);
      end
    end
    if (cmd.cyc) begin
      if (day_big) begin
        day  <= day - CYC_D;
        year <= year + CYC_Y;
      end else begin
        day  <= day + CYC_D;
        year <= year - CYC_Y;
      end
    end
    if (cmd.back) begin
      mon <= MONTH_BITS'(prev_mon);
      day <= day + $signed({{(DW-5){1'b0}}, len_back});
      if (wrap_back) begin
        year <= year - ONE_Y;
        ymod <= ymod_dec(ymod);
      end
    end
    if (cmd.fwd) begin
      day <= day - $signed({{(DW-5){1'b0}}, len_cur});
      if (mon_lo == DECEMBER) begin
        mon  <= '0;
        year <= year + ONE_Y;
        ymod <= ymod_inc(ymod);
      end else begin
        mon <= MONTH_BITS'(mon_lo + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.store) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      day_out       <= day[4:0];
      month_out     <= mon_lo;
      year_out      <= year[YEAR_BITS-1:0];
      year_overflow <= !((&year_hi) || !(|year_hi));
    end
  end

`ifndef NO_ASSERTIONS
  a_store_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> out_valid)
    else $error("result register not valid after store");

  a_month_norm: assert property (@(posedge clk) disable iff (rst)
    (cmd.back || cmd.fwd || cmd.store) |-> (!mon_neg && !mon_big))
    else $error("month not folded before day stepping");

  a_ymod_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.fold || cmd.back || cmd.fwd || cmd.store) |-> (ymod <= YMOD_MAX))
    else $error("year residue out of range");

  a_day_norm: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (!day[DW-1] && (day < $signed({{(DW-5){1'b0}}, len_cur}))))
    else $error("day not normalized at store");
`endif

endmodule
`default_nettype wire

// File: rtl/calendar_date_normalizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_normalizer_top
// Gregorian date normalizer with valid/ready input and result channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input transfer: day_offset, month_offset, year_in when in_valid & in_ready.
//   Result transfer: day_out, month_out, year_out, year_overflow when
//   out_valid & out_ready. Exactly one result per input item.
//   One item is processed at a time; in_ready is high only while idle.
//   Steps per item, in order:
//     load, year / 25 by reciprocal multiply, year mod 400 with sign fix,
//     month fold steps (at most 22), 400-year moves (one per 146097 days),
//     month stepping (up to about 1080 months at 16-bit day offsets),
//     an exit from each of the fold, 400-year, back and forward states, store.
//   The month stepping loop, one month per cycle, dominates the processing time.
//   The result sits in an output register, so the next item is accepted while
//   it waits; a stalled receiver only delays the store of the following item.
//   Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module calendar_date_normalizer_top
  import cdn_pkg::*;
#(
  parameter int DAY_BITS  = DEF_DAY_BITS,
  parameter int YEAR_BITS = DEF_YEAR_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DAY_BITS-1:0]   day_offset,
  input  wire logic signed [MONTH_BITS-1:0] month_offset,
  input  wire logic signed [YEAR_BITS-1:0]  year_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [4:0]                        day_out,
  output logic [3:0]                        month_out,
  output logic signed [YEAR_BITS-1:0]       year_out,
  output logic                              year_overflow
);

  cdn_cmd_t cmd;
  cdn_sts_t sts;

  cdn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdn_dp #(
    .DAY_BITS  (DAY_BITS),
    .YEAR_BITS (YEAR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .day_offset    (day_offset),
    .month_offset  (month_offset),
    .year_in       (year_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .day_out       (day_out),
    .month_out     (month_out),
    .year_out      (year_out),
    .year_overflow (year_overflow)
  );

endmodule
`default_nettype wire
